FILE: rtl/core/i2cem_pkg.sv
// Shared types and constants for the I2C EEPROM transaction master.
package i2cem_pkg;

    localparam int          CfgDataWidth   = 32;
    localparam int          CfgAddrWidth   = 3;

    localparam logic [1:0]  CMD_TICK       = 2'd0;
    localparam logic [1:0]  CMD_WRITE      = 2'd1;
    localparam logic [1:0]  CMD_READ       = 2'd2;

    localparam logic        REG_ACK_WAIT   = 1'b0;
    localparam logic        REG_STOP_GAP   = 1'b1;

    localparam logic [7:0]  ACK_WAIT_RESET = 8'd250;
    localparam logic [7:0]  STOP_GAP_RESET = 8'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] dev_addr;
        logic [7:0] sub_addr;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_byte;
        logic       byte_taken;
        logic       ack_done;
        logic       ack_seen;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0] ack_wait_limit;
        logic [7:0] stop_gap_ticks;
    } t_cfg;

endpackage

FILE: rtl/core/i2cem_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface i2cem_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/i2cem_seq.sv
// Bus phase sequencer: one phase step and one result per advance.
module i2cem_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  i2cem_pkg::t_in_item   i_item,
    input  i2cem_pkg::t_cfg       i_cfg,
    output i2cem_pkg::t_out_item  o_res
);
    import i2cem_pkg::*;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST1  = 5'd1;
    localparam logic [4:0] PH_ST2  = 5'd2;
    localparam logic [4:0] PH_ST3  = 5'd3;
    localparam logic [4:0] PH_TXL  = 5'd4;
    localparam logic [4:0] PH_TXH  = 5'd5;
    localparam logic [4:0] PH_AKR  = 5'd6;
    localparam logic [4:0] PH_AKH  = 5'd7;
    localparam logic [4:0] PH_AKL  = 5'd8;
    localparam logic [4:0] PH_RXL  = 5'd9;
    localparam logic [4:0] PH_RXH  = 5'd10;
    localparam logic [4:0] PH_PAS  = 5'd11;
    localparam logic [4:0] PH_PAH  = 5'd12;
    localparam logic [4:0] PH_PAL  = 5'd13;
    localparam logic [4:0] PH_SP1  = 5'd14;
    localparam logic [4:0] PH_SP2  = 5'd15;
    localparam logic [4:0] PH_SP3  = 5'd16;
    localparam logic [4:0] PH_GAP  = 5'd17;

    localparam logic [1:0] STG_SLAVE = 2'd0;
    localparam logic [1:0] STG_SUB   = 2'd1;
    localparam logic [1:0] STG_RADDR = 2'd2;
    localparam logic [1:0] STG_DATA  = 2'd3;

    logic [4:0] r_phase,      n_phase;
    logic [3:0] r_bit_index,  n_bit_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [8:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_target,     n_target;
    logic [7:0] r_mem_addr,   n_mem_addr;
    logic       r_reading,    n_reading;
    logic [7:0] r_wait,       n_wait;
    logic [1:0] r_stage,      n_stage;

    logic [3:0] bit_inc;
    logic [7:0] wait_inc;
    logic [8:0] bytes_dec;
    logic [7:0] rx_byte;
    logic       last_rx;

    assign bit_inc   = r_bit_index + 4'd1;
    assign wait_inc  = r_wait + 8'd1;
    assign bytes_dec = r_bytes_left - 9'd1;
    assign rx_byte   = {r_shift_byte[6:0], i_item.sda_in};
    assign last_rx   = (r_bytes_left == 9'd1);

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_bytes_left = r_bytes_left;
        n_target     = r_target;
        n_mem_addr   = r_mem_addr;
        n_reading    = r_reading;
        n_wait       = r_wait;
        n_stage      = r_stage;
        o_res        = '0;
        o_res.scl         = 1'b1;
        o_res.sda_release = 1'b1;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.command == CMD_WRITE || i_item.command == CMD_READ) begin
                    n_target     = {i_item.dev_addr[7:1], 1'b0};
                    n_mem_addr   = i_item.sub_addr;
                    n_bytes_left = (i_item.byte_count == 8'd0) ? 9'd256
                                                              : {1'b0, i_item.byte_count};
                    n_reading    = (i_item.command == CMD_READ);
                    n_stage      = STG_SLAVE;
                    n_phase      = PH_ST1;
                end
            end
            PH_ST1: n_phase = PH_ST2;
            PH_ST2: begin
                o_res.sda_release = 1'b0;
                n_phase = PH_ST3;
            end
            PH_ST3: begin
                o_res.scl         = 1'b0;
                o_res.sda_release = 1'b0;
                n_shift_byte = (r_stage == STG_RADDR) ? {r_target[7:1], 1'b1} : r_target;
                n_bit_index  = 4'd0;
                n_phase      = PH_TXL;
            end
            PH_TXL: begin
                o_res.scl         = 1'b0;
                o_res.sda_release = r_shift_byte[7];
                n_phase = PH_TXH;
            end
            PH_TXH: begin
                o_res.sda_release = r_shift_byte[7];
                n_shift_byte = {r_shift_byte[6:0], 1'b0};
                n_bit_index  = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_wait  = 8'd0;
                    n_phase = PH_AKR;
                end else begin
                    n_phase = PH_TXL;
                end
            end
            PH_AKR: begin
                o_res.scl = 1'b0;
                n_phase = PH_AKH;
            end
            PH_AKH: begin
                if (!i_item.sda_in) begin
                    o_res.ack_done = 1'b1;
                    o_res.ack_seen = 1'b1;
                    n_phase = PH_AKL;
                end else if (r_wait >= i_cfg.ack_wait_limit) begin
                    o_res.ack_done = 1'b1;
                    n_phase = PH_AKL;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_AKL: begin
                o_res.scl = 1'b0;
                unique case (r_stage)
                    STG_SLAVE: begin
                        n_stage      = STG_SUB;
                        n_shift_byte = r_mem_addr;
                        n_bit_index  = 4'd0;
                        n_phase      = PH_TXL;
                    end
                    STG_SUB: begin
                        if (r_reading) begin
                            n_stage = STG_RADDR;
                            n_phase = PH_ST1;
                        end else begin
                            n_stage          = STG_DATA;
                            n_shift_byte     = i_item.write_data;
                            n_bit_index      = 4'd0;
                            n_phase          = PH_TXL;
                            o_res.byte_taken = 1'b1;
                            o_res.last_byte  = last_rx;
                        end
                    end
                    STG_RADDR: begin
                        n_bit_index  = 4'd0;
                        n_shift_byte = 8'd0;
                        n_phase      = PH_RXL;
                    end
                    default: begin
                        n_bytes_left = bytes_dec;
                        if (bytes_dec == 9'd0) begin
                            n_phase = PH_SP1;
                        end else begin
                            n_shift_byte     = i_item.write_data;
                            n_bit_index      = 4'd0;
                            n_phase          = PH_TXL;
                            o_res.byte_taken = 1'b1;
                            o_res.last_byte  = (bytes_dec == 9'd1);
                        end
                    end
                endcase
            end
            PH_RXL: begin
                o_res.scl = 1'b0;
                n_phase = PH_RXH;
            end
            PH_RXH: begin
                n_shift_byte = rx_byte;
                n_bit_index  = bit_inc;
                if (bit_inc >= 4'd8) begin
                    o_res.read_valid = 1'b1;
                    o_res.read_data  = rx_byte;
                    o_res.last_byte  = last_rx;
                    n_phase = PH_PAS;
                end else begin
                    n_phase = PH_RXL;
                end
            end
            PH_PAS: begin
                o_res.scl         = 1'b0;
                o_res.sda_release = last_rx;
                n_phase = PH_PAH;
            end
            PH_PAH: begin
                o_res.sda_release = last_rx;
                n_phase = PH_PAL;
            end
            PH_PAL: begin
                o_res.scl         = 1'b0;
                o_res.sda_release = last_rx;
                n_bytes_left = bytes_dec;
                if (bytes_dec == 9'd0) begin
                    n_phase = PH_SP1;
                end else begin
                    n_bit_index  = 4'd0;
                    n_shift_byte = 8'd0;
                    n_phase      = PH_RXL;
                end
            end
            PH_SP1: begin
                o_res.scl         = 1'b0;
                o_res.sda_release = 1'b0;
                n_phase = PH_SP2;
            end
            PH_SP2: begin
                o_res.sda_release = 1'b0;
                n_phase = PH_SP3;
            end
            PH_SP3: begin
                n_wait  = 8'd0;
                n_phase = (i_cfg.stop_gap_ticks == 8'd0) ? PH_IDLE : PH_GAP;
            end
            PH_GAP: begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.stop_gap_ticks) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_bytes_left <= '0;
            r_target     <= '0;
            r_mem_addr   <= '0;
            r_reading    <= 1'b0;
            r_wait       <= '0;
            r_stage      <= STG_SLAVE;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_bytes_left <= n_bytes_left;
            r_target     <= n_target;
            r_mem_addr   <= n_mem_addr;
            r_reading    <= n_reading;
            r_wait       <= n_wait;
            r_stage      <= n_stage;
        end
    end

endmodule

FILE: rtl/core/i2c_eeprom_transaction_master.sv
// Top level: I2C EEPROM transaction master with tick channels and APB registers.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   i_cmd    | in        | command, dev_addr, sub_addr, byte_count, ...
//   o_res    | out       | scl, sda_release, read_data, flags, busy_res
//   APB      | in/out    | ack_wait_limit (0x0), stop_gap_ticks (0x4)
//
// One tick per cycle unless stalled: each transfer on i_cmd steps the phase sequencer
// once and lands its result in the output register on the same edge.
// The output register is refilled while its result leaves, so a stall only
// holds i_cmd when o_res is full and not taken.
// Synchronous reset returns the sequencer to idle with both lines released.
module i2c_eeprom_transaction_master (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    i2cem_if.sink                              i_cmd,
    i2cem_if.source                            o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cem_pkg::CfgAddrWidth-1:0] paddr,
    input  logic [i2cem_pkg::CfgDataWidth-1:0] pwdata,
    output logic [i2cem_pkg::CfgDataWidth-1:0] prdata,
    output logic                               pready
);
    import i2cem_pkg::*;

    t_cfg      r_cfg;
    t_out_item n_out;
    t_out_item r_out;
    logic      r_out_valid;
    logic      adv;
    logic      cfg_wr;
    logic      reg_sel;

    assign reg_sel     = paddr[2];
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign prdata      = (reg_sel == REG_ACK_WAIT)
                       ? {{(CfgDataWidth-8){1'b0}}, r_cfg.ack_wait_limit}
                       : {{(CfgDataWidth-8){1'b0}}, r_cfg.stop_gap_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_wait_limit <= ACK_WAIT_RESET;
            r_cfg.stop_gap_ticks <= STOP_GAP_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ACK_WAIT: r_cfg.ack_wait_limit <= pwdata[7:0];
                REG_STOP_GAP: r_cfg.stop_gap_ticks <= pwdata[7:0];
                default:      r_cfg.stop_gap_ticks <= r_cfg.stop_gap_ticks;
            endcase
        end
    end

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign adv         = i_cmd.valid && i_cmd.ready;

    i2cem_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (i_cmd.data),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

FILE: sim/tb_i2c_eeprom_transaction_master.sv
// Testbench for the I2C EEPROM transaction master: random ticks checked against a phase predictor.
`timescale 1ns / 1ps

module tb_i2c_eeprom_transaction_master;
    import i2cem_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_TXL, PH_TXH, PH_AKR, PH_AKH, PH_AKL,
        PH_RXL, PH_RXH, PH_PAS, PH_PAH, PH_PAL, PH_SP1, PH_SP2, PH_SP3, PH_GAP
    } t_bus_phase;

    typedef enum logic [1:0] {
        STG_SLAVE, STG_SUB, STG_RADDR, STG_DATA
    } t_byte_stage;

    class i2c_line_checker;
        t_out_item   expected_lines[$];
        int unsigned mismatches;
        logic [7:0]  ack_limit;
        logic [7:0]  gap_ticks;
        t_bus_phase  phase;
        t_byte_stage stage;
        logic [3:0]  bit_idx;
        logic [7:0]  shreg;
        logic [8:0]  left;
        logic [7:0]  target;
        logic [7:0]  mem_addr;
        logic        reading;
        logic [7:0]  wait_cnt;

        function new();
            mismatches = 0;
            reset_model();
        endfunction

        function void reset_model();
            ack_limit = ACK_WAIT_RESET;
            gap_ticks = STOP_GAP_RESET;
            phase     = PH_IDLE;
            stage     = STG_SLAVE;
            bit_idx   = '0;
            shreg     = '0;
            left      = '0;
            target    = '0;
            mem_addr  = '0;
            reading   = 1'b0;
            wait_cnt  = '0;
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == REG_ACK_WAIT) ack_limit = value;
            else gap_ticks = value;
        endfunction

        function void load_tx(logic [7:0] b);
            shreg   = b;
            bit_idx = '0;
            phase   = PH_TXL;
        endfunction

        function void take_tick(t_in_item it);
            t_out_item r;
            r             = '0;
            r.scl         = 1'b1;
            r.sda_release = 1'b1;
            case (phase)
                PH_IDLE: begin
                    if (it.command == CMD_WRITE || it.command == CMD_READ) begin
                        target   = it.dev_addr & 8'hFE;
                        mem_addr = it.sub_addr;
                        left     = (it.byte_count == 8'd0) ? 9'd256 : {1'b0, it.byte_count};
                        reading  = (it.command == CMD_READ);
                        stage    = STG_SLAVE;
                        phase    = PH_ST1;
                    end
                end
                PH_ST1: phase = PH_ST2;
                PH_ST2: begin
                    r.sda_release = 1'b0;
                    phase         = PH_ST3;
                end
                PH_ST3: begin
                    r.scl         = 1'b0;
                    r.sda_release = 1'b0;
                    load_tx((stage == STG_RADDR) ? (target | 8'h01) : target);
                end
                PH_TXL: begin
                    r.sda_release = shreg[7];
                    r.scl         = 1'b0;
                    phase         = PH_TXH;
                end
                PH_TXH: begin
                    r.sda_release = shreg[7];
                    shreg         = {shreg[6:0], 1'b0};
                    bit_idx       = bit_idx + 4'd1;
                    if (bit_idx >= 4'd8) begin
                        wait_cnt = '0;
                        phase    = PH_AKR;
                    end else begin
                        phase = PH_TXL;
                    end
                end
                PH_AKR: begin
                    r.scl = 1'b0;
                    phase = PH_AKH;
                end
                PH_AKH: begin
                    if (!it.sda_in) begin
                        r.ack_done = 1'b1;
                        r.ack_seen = 1'b1;
                        phase      = PH_AKL;
                    end else if (wait_cnt >= ack_limit) begin
                        r.ack_done = 1'b1;
                        phase      = PH_AKL;
                    end else begin
                        wait_cnt = wait_cnt + 8'd1;
                    end
                end
                PH_AKL: begin
                    r.scl = 1'b0;
                    case (stage)
                        STG_SLAVE: begin
                            stage = STG_SUB;
                            load_tx(mem_addr);
                        end
                        STG_SUB: begin
                            if (reading) begin
                                stage = STG_RADDR;
                                phase = PH_ST1;
                            end else begin
                                stage        = STG_DATA;
                                load_tx(it.write_data);
                                r.byte_taken = 1'b1;
                                r.last_byte  = (left == 9'd1);
                            end
                        end
                        STG_RADDR: begin
                            bit_idx = '0;
                            shreg   = '0;
                            phase   = PH_RXL;
                        end
                        default: begin
                            left = left - 9'd1;
                            if (left == 9'd0) begin
                                phase = PH_SP1;
                            end else begin
                                load_tx(it.write_data);
                                r.byte_taken = 1'b1;
                                r.last_byte  = (left == 9'd1);
                            end
                        end
                    endcase
                end
                PH_RXL: begin
                    r.scl = 1'b0;
                    phase = PH_RXH;
                end
                PH_RXH: begin
                    shreg   = {shreg[6:0], it.sda_in};
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx >= 4'd8) begin
                        r.read_valid = 1'b1;
                        r.read_data  = shreg;
                        r.last_byte  = (left == 9'd1);
                        phase        = PH_PAS;
                    end else begin
                        phase = PH_RXL;
                    end
                end
                PH_PAS: begin
                    r.scl         = 1'b0;
                    r.sda_release = (left == 9'd1);
                    phase         = PH_PAH;
                end
                PH_PAH: begin
                    r.sda_release = (left == 9'd1);
                    phase         = PH_PAL;
                end
                PH_PAL: begin
                    r.scl         = 1'b0;
                    r.sda_release = (left == 9'd1);
                    left          = left - 9'd1;
                    if (left == 9'd0) begin
                        phase = PH_SP1;
                    end else begin
                        bit_idx = '0;
                        shreg   = '0;
                        phase   = PH_RXL;
                    end
                end
                PH_SP1: begin
                    r.scl         = 1'b0;
                    r.sda_release = 1'b0;
                    phase         = PH_SP2;
                end
                PH_SP2: begin
                    r.sda_release = 1'b0;
                    phase         = PH_SP3;
                end
                PH_SP3: begin
                    wait_cnt = '0;
                    phase    = (gap_ticks == 8'd0) ? PH_IDLE : PH_GAP;
                end
                PH_GAP: begin
                    wait_cnt = wait_cnt + 8'd1;
                    if (wait_cnt >= gap_ticks) phase = PH_IDLE;
                end
                default: phase = PH_IDLE;
            endcase
            r.busy_res = (phase != PH_IDLE);
            expected_lines.push_back(r);
        endfunction

        function string show(t_out_item v);
            return $sformatf({"scl=%0b sda=%0b rd=%02h rv=%0b last=%0b ",
                              "tk=%0b ad=%0b as=%0b busy=%0b"},
                             v.scl, v.sda_release, v.read_data, v.read_valid, v.last_byte,
                             v.byte_taken, v.ack_done, v.ack_seen, v.busy_res);
        endfunction

        function void check_lines(t_out_item got);
            t_out_item exp;
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            exp = expected_lines.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", show(exp));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CfgAddrWidth-1:0] paddr;
    logic [CfgDataWidth-1:0] pwdata;
    logic [CfgDataWidth-1:0] prdata;
    logic                    pready;

    i2cem_if #(.T(t_in_item))  cmd_if ();
    i2cem_if #(.T(t_out_item)) res_if ();

    i2c_line_checker sb;
    int              tx_idle_pct;
    int              rx_idle_pct;
    int unsigned     busy_ticks;
    int unsigned     cycle_count;

    i2c_eeprom_transaction_master dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_lines(res_if.data);
        res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic t_in_item make_tick(logic [1:0] cmd, int ack_pct);
        t_in_item it;
        it.command    = cmd;
        it.dev_addr   = 8'($urandom);
        it.sub_addr   = 8'($urandom);
        it.byte_count = 8'($urandom);
        it.write_data = 8'($urandom);
        if (sb.phase == PH_AKH) it.sda_in = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
        else it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_tick(t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.take_tick(it);
    endtask

    task automatic run_txn(logic [1:0] cmd, logic [7:0] slave, logic [7:0] sub,
                           logic [7:0] count, int ack_pct);
        t_in_item it;
        logic [1:0] noise;
        it            = make_tick(cmd, ack_pct);
        it.dev_addr   = slave;
        it.sub_addr   = sub;
        it.byte_count = count;
        send_tick(it);
        while (sb.phase != PH_IDLE) begin
            noise = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK;
            send_tick(make_tick(noise, ack_pct));
            busy_ticks++;
        end
    endtask

    task automatic drain_and_hold();
        cmd_if.valid <= 1'b0;
        while (sb.expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CfgAddrWidth'(4 * int'(idx));
        pwdata  <= CfgDataWidth'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] ack_lim, logic [7:0] gap);
        drain_and_hold();
        write_reg(REG_ACK_WAIT, ack_lim);
        write_reg(REG_STOP_GAP, gap);
    endtask

    task automatic random_phase(int tx_pct, int rx_pct, logic [7:0] ack_lim, logic [7:0] gap);
        int unsigned target;
        logic [1:0]  cmd;
        logic [7:0]  cnt;
        int          pick;
        int          pct;
        set_regs(ack_lim, gap);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = busy_ticks + 100;
        while (busy_ticks < target) begin
            repeat ($urandom_range(0, 2))
                send_tick(make_tick($urandom_range(0, 1) ? CMD_TICK : CMD_SPARE, 100));
            cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            cnt  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 4))
                                                : 8'($urandom_range(5, 16));
            pick = $urandom_range(0, 9);
            pct  = (pick < 7) ? 100 : (pick < 9) ? 40 : 0;
            run_txn(cmd, 8'($urandom), 8'($urandom), cnt, pct);
        end
    endtask

    initial begin
        sb           = new();
        cycle_count  = 0;
        busy_ticks   = 0;
        tx_idle_pct  = 31;
        rx_idle_pct  = 53;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_model();

        run_txn(CMD_TICK, 8'h00, 8'h00, 8'h00, 100);
        run_txn(CMD_SPARE, 8'hFF, 8'hFF, 8'hFF, 100);
        run_txn(CMD_WRITE, 8'hFF, 8'h00, 8'd1, 100);
        run_txn(CMD_READ, 8'h00, 8'hFF, 8'd1, 100);

        set_regs(8'd0, 8'd0);
        run_txn(CMD_READ, 8'hA1, 8'h3C, 8'd2, 0);
        run_txn(CMD_WRITE, 8'h1E, 8'hC3, 8'd3, 50);

        random_phase(31, 53, 8'd5, 8'd2);
        random_phase(53, 31, 8'($urandom_range(0, 12)), 8'($urandom_range(0, 6)));
        random_phase(0, 0, 8'd1, 8'd0);

        drain_and_hold();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_lines.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
